@@ rtl/hgov_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hgov_pkg
// Types and constants shared by the core hotplug governor modules.
// ----------------------------------------------------------------------------
package hgov_pkg;

  // At most four cores are modeled: each item carries four loads and
  // three frequencies; the configuration holds four plug thresholds.
  localparam int unsigned MAX_LANES  = 4;
  localparam int unsigned LANE_IDX_W = 2;

  localparam int unsigned CMD_W    = 2;
  localparam int unsigned LOAD_W   = 7;
  localparam int unsigned FREQ_W   = 22;
  localparam int unsigned PRIO_W   = 7;
  localparam int unsigned CNT_W    = 3;
  localparam int unsigned HOLD_W   = 6;
  localparam int unsigned PRIOS_W  = MAX_LANES * PRIO_W;
  localparam int unsigned ACTION_W = 2;
  localparam int unsigned SUM_W    = 9;

  // Floor division by three for sums below 512: (s * 171) >> 9.
  localparam int unsigned DIV3_MUL_W = 8;
  localparam logic [DIV3_MUL_W-1:0] DIV3_MUL = 8'd171;
  localparam int unsigned DIV3_SHIFT = 9;

  localparam int unsigned PADDR_W = 5;
  localparam int unsigned PDATA_W = 32;

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK       = 2'd0,
    CMD_SCREEN_OFF = 2'd1,
    CMD_SCREEN_ON  = 2'd2
  } cmd_e;

  typedef enum logic [ACTION_W-1:0] {
    ACT_NONE   = 2'd0,
    ACT_UP     = 2'd1,
    ACT_DOWN   = 2'd2,
    ACT_SCREEN = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    REG_LOAD_THRESHOLD   = 3'd0,
    REG_MIN_CORES        = 3'd1,
    REG_MAX_CORES        = 3'd2,
    REG_UP_HOLD_TICKS    = 3'd3,
    REG_DOWN_HOLD_TICKS  = 3'd4,
    REG_SCREEN_OFF_CORES = 3'd5,
    REG_CORE_PRIORITIES  = 3'd6
  } reg_idx_e;

  typedef struct packed {
    logic [LOAD_W-1:0]  load_threshold;
    logic [CNT_W-1:0]   min_cores;
    logic [CNT_W-1:0]   max_cores;
    logic [HOLD_W-1:0]  up_hold_ticks;
    logic [HOLD_W-1:0]  down_hold_ticks;
    logic [CNT_W-1:0]   screen_off_cores;
    logic [PRIOS_W-1:0] core_priorities;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    load_threshold:   7'd80,
    min_cores:        3'd1,
    max_cores:        3'd4,
    up_hold_ticks:    6'd2,
    down_hold_ticks:  6'd6,
    screen_off_cores: 3'd1,
    core_priorities:  28'd147956550
  };

  // What one lane hands to the merging stage.
  typedef struct packed {
    logic              online;
    logic [LOAD_W-1:0] load;
    logic [PRIO_W-1:0] prio;
    logic              freq_ok;
    logic [FREQ_W-1:0] freq;
  } lane_t;

  // What the merging stage hands to the decision stage.
  typedef struct packed {
    logic [SUM_W-1:0]      sum;
    logic [CNT_W-1:0]      count;
    logic                  victim_ok;
    logic [LANE_IDX_W-1:0] victim;
    logic                  first_off_ok;
    logic [LANE_IDX_W-1:0] first_off;
  } merge_t;

endpackage

@@ rtl/hgov_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hgov_if
// Valid/ready channels for governor items and governor results.
// ----------------------------------------------------------------------------
interface hgov_in_if;
  import hgov_pkg::*;

  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  cmd;
  logic [LOAD_W-1:0] load_core0;
  logic [LOAD_W-1:0] load_core1;
  logic [LOAD_W-1:0] load_core2;
  logic [LOAD_W-1:0] load_core3;
  logic [FREQ_W-1:0] freq_core1;
  logic [FREQ_W-1:0] freq_core2;
  logic [FREQ_W-1:0] freq_core3;

  modport source (
    output valid, cmd, load_core0, load_core1, load_core2, load_core3,
           freq_core1, freq_core2, freq_core3,
    input  ready
  );

  modport sink (
    input  valid, cmd, load_core0, load_core1, load_core2, load_core3,
           freq_core1, freq_core2, freq_core3,
    output ready
  );
endinterface

interface hgov_out_if;
  import hgov_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [MAX_LANES-1:0]  online_mask;
  logic [ACTION_W-1:0]   action;
  logic [LANE_IDX_W-1:0] changed_core;
  logic [LOAD_W-1:0]     average_load;

  modport source (
    output valid, online_mask, action, changed_core, average_load,
    input  ready
  );

  modport sink (
    input  valid, online_mask, action, changed_core, average_load,
    output ready
  );
endinterface

@@ rtl/hgov_cfg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hgov_cfg
// APB register file holding the governor's configuration.
// ----------------------------------------------------------------------------
module hgov_cfg (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     psel_i,
  input  logic                     penable_i,
  input  logic                     pwrite_i,
  input  logic [hgov_pkg::PADDR_W-1:0] paddr_i,
  input  logic [hgov_pkg::PDATA_W-1:0] pwdata_i,
  output logic [hgov_pkg::PDATA_W-1:0] prdata_o,
  output logic                     pready_o,
  output hgov_pkg::cfg_t           cfg_o
);
  import hgov_pkg::*;

  cfg_t     cfg_q;
  reg_idx_e reg_idx;

  assign reg_idx  = reg_idx_e'(paddr_i[PADDR_W-1:2]);
  assign pready_o = 1'b1;
  assign cfg_o    = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else if (psel_i && penable_i && pwrite_i) begin
      case (reg_idx)
        REG_LOAD_THRESHOLD:   cfg_q.load_threshold   <= pwdata_i[LOAD_W-1:0];
        REG_MIN_CORES:        cfg_q.min_cores        <= pwdata_i[CNT_W-1:0];
        REG_MAX_CORES:        cfg_q.max_cores        <= pwdata_i[CNT_W-1:0];
        REG_UP_HOLD_TICKS:    cfg_q.up_hold_ticks    <= pwdata_i[HOLD_W-1:0];
        REG_DOWN_HOLD_TICKS:  cfg_q.down_hold_ticks  <= pwdata_i[HOLD_W-1:0];
        REG_SCREEN_OFF_CORES: cfg_q.screen_off_cores <= pwdata_i[CNT_W-1:0];
        REG_CORE_PRIORITIES:  cfg_q.core_priorities  <= pwdata_i[PRIOS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_LOAD_THRESHOLD:   prdata_o = PDATA_W'(cfg_q.load_threshold);
      REG_MIN_CORES:        prdata_o = PDATA_W'(cfg_q.min_cores);
      REG_MAX_CORES:        prdata_o = PDATA_W'(cfg_q.max_cores);
      REG_UP_HOLD_TICKS:    prdata_o = PDATA_W'(cfg_q.up_hold_ticks);
      REG_DOWN_HOLD_TICKS:  prdata_o = PDATA_W'(cfg_q.down_hold_ticks);
      REG_SCREEN_OFF_CORES: prdata_o = PDATA_W'(cfg_q.screen_off_cores);
      REG_CORE_PRIORITIES:  prdata_o = PDATA_W'(cfg_q.core_priorities);
      default:              prdata_o = '0;
    endcase
  end

endmodule

@@ rtl/hgov_lane.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hgov_lane
// Per-core lane: gates one core's load and frequency eligibility by its
// online state and registers the result for the merging stage.
// ----------------------------------------------------------------------------
module hgov_lane (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic                        online_i,
  input  logic                        freq_en_i,
  input  logic [hgov_pkg::LOAD_W-1:0] load_i,
  input  logic [hgov_pkg::PRIO_W-1:0] prio_i,
  input  logic [hgov_pkg::FREQ_W-1:0] freq_i,
  output hgov_pkg::lane_t             lane_o
);
  import hgov_pkg::*;

  lane_t lane_d;
  lane_t lane_q;

  always_comb begin
    lane_d.online  = online_i;
    lane_d.load    = online_i ? load_i : '0;
    lane_d.prio    = prio_i;
    // Core 0 never competes in the lowest-frequency search.
    lane_d.freq_ok = online_i && freq_en_i;
    lane_d.freq    = freq_i;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lane_q <= lane_d;
    end
  end

  assign lane_o = lane_q;

endmodule

@@ rtl/hgov_merge.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hgov_merge
// Combines the lanes: load sum, online count, the core to take down and
// the lowest offline core, registered for the decision stage.
// ----------------------------------------------------------------------------
module hgov_merge #(
  parameter int unsigned LANES = 4
) (
  input  logic            clk_i,
  input  logic            en_i,
  input  hgov_pkg::lane_t lane_i [LANES],
  output hgov_pkg::merge_t merge_o
);
  import hgov_pkg::*;

  merge_t merge_d;
  merge_t merge_q;

  always_comb begin
    logic [PRIO_W-1:0]     p_thr;
    logic [LANE_IDX_W-1:0] p_core;
    logic                  shared;
    logic [FREQ_W-1:0]     l_freq;
    logic [LANE_IDX_W-1:0] l_core;
    logic                  have_l;
    logic [SUM_W-1:0]      sum;
    logic [CNT_W-1:0]      count;
    logic [LANE_IDX_W-1:0] victim;

    p_thr  = '0;
    p_core = '0;
    shared = 1'b0;
    l_freq = '0;
    l_core = '0;
    have_l = 1'b0;
    sum    = '0;
    count  = '0;
    merge_d.first_off_ok = 1'b0;
    merge_d.first_off    = '0;

    for (int c = 0; c < LANES; c++) begin
      sum   = sum + SUM_W'(lane_i[c].load);
      count = count + CNT_W'(lane_i[c].online);
      if (lane_i[c].online) begin
        // Core 0 or a tie with the running highest marks the threshold as
        // shared; a strictly higher threshold takes the candidacy alone.
        if (c == 0 || lane_i[c].prio == p_thr) begin
          p_thr  = lane_i[c].prio;
          p_core = LANE_IDX_W'(c);
          shared = 1'b1;
        end else if (lane_i[c].prio > p_thr) begin
          p_thr  = lane_i[c].prio;
          p_core = LANE_IDX_W'(c);
          shared = 1'b0;
        end
      end
      if (lane_i[c].freq_ok && (!have_l || lane_i[c].freq < l_freq)) begin
        l_freq = lane_i[c].freq;
        l_core = LANE_IDX_W'(c);
        have_l = 1'b1;
      end
    end

    // Scan downward so that the lowest offline core is left standing.
    for (int c = LANES - 1; c >= 0; c--) begin
      if (!lane_i[c].online) begin
        merge_d.first_off_ok = 1'b1;
        merge_d.first_off    = LANE_IDX_W'(c);
      end
    end

    if (shared) begin
      victim = have_l ? l_core : '0;
    end else begin
      victim = p_core;
    end

    merge_d.sum       = sum;
    merge_d.count     = count;
    merge_d.victim    = victim;
    merge_d.victim_ok = (victim != '0);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      merge_q <= merge_d;
    end
  end

  assign merge_o = merge_q;

endmodule

@@ rtl/core_hotplug_governor_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// core_hotplug_governor_unit
// Decides which cores are online from per-tick loads, hold counters and
// screen events, reporting one result per item.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake            Carries
//  in_i      sink       valid/ready          cmd, four loads, three freqs
//  out_o     source     valid/ready          online mask, action, core, avg
//  APB       slave      psel/penable/pready  seven configuration registers
//
//  An item passes through accept, lane capture, merge and decision. The next
//  item is accepted in the cycle after the decision is committed.
//  A result waiting on out_o does not block acceptance; only the decision
//  stage waits while the output register is still full.
//  Reset puts all modeled cores online, clears the hold counters and leaves
//  ticks active; configuration returns to its reset values.
// ----------------------------------------------------------------------------
module core_hotplug_governor_unit #(
  parameter int unsigned NUM_CORES = 4
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  hgov_in_if.sink                      in_i,
  hgov_out_if.source                   out_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [hgov_pkg::PADDR_W-1:0] paddr,
  input  logic [hgov_pkg::PDATA_W-1:0] pwdata,
  output logic [hgov_pkg::PDATA_W-1:0] prdata,
  output logic                         pready
);
  import hgov_pkg::*;

  localparam int unsigned LANES = (NUM_CORES < MAX_LANES) ? NUM_CORES : MAX_LANES;
  localparam logic [MAX_LANES-1:0] LANE_MASK = {MAX_LANES{1'b1}} >> (MAX_LANES - LANES);
  localparam int unsigned PROD_W = SUM_W + DIV3_MUL_W;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_LANE   = 4'b0010,
    ST_MERGE  = 4'b0100,
    ST_DECIDE = 4'b1000
  } state_e;

  state_e state_q, state_d;
  cfg_t   cfg;
  merge_t merge_q;
  lane_t  lane_q [LANES];

  logic [CMD_W-1:0]     cmd_q;
  logic [LOAD_W-1:0]    load_q [MAX_LANES];
  logic [FREQ_W-1:0]    freq_q [MAX_LANES];

  logic [MAX_LANES-1:0] core_online_q, online_d;
  logic [HOLD_W-1:0]    up_q, up_d;
  logic [HOLD_W-1:0]    down_q, down_d;
  logic                 paused_q, paused_d;

  logic                  out_valid_q;
  logic [MAX_LANES-1:0]  out_mask_q;
  action_e               out_action_q, action_d;
  logic [LANE_IDX_W-1:0] out_core_q, changed_d;
  logic [LOAD_W-1:0]     out_avg_q, avg_d;

  logic                  in_accept;
  logic                  commit;
  logic [PROD_W-1:0]     prod3;
  logic [SUM_W-1:0]      avg_full;

  hgov_cfg u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel_i    (psel),
    .penable_i (penable),
    .pwrite_i  (pwrite),
    .paddr_i   (paddr),
    .pwdata_i  (pwdata),
    .prdata_o  (prdata),
    .pready_o  (pready),
    .cfg_o     (cfg)
  );

  // --------------------------------------------------------------------------
  // Item capture
  // --------------------------------------------------------------------------
  assign in_i.ready = (state_q == ST_IDLE);
  assign in_accept  = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      cmd_q     <= in_i.cmd;
      load_q[0] <= in_i.load_core0;
      load_q[1] <= in_i.load_core1;
      load_q[2] <= in_i.load_core2;
      load_q[3] <= in_i.load_core3;
      freq_q[0] <= '0;
      freq_q[1] <= in_i.freq_core1;
      freq_q[2] <= in_i.freq_core2;
      freq_q[3] <= in_i.freq_core3;
    end
  end

  // --------------------------------------------------------------------------
  // Lanes and merge
  // --------------------------------------------------------------------------
  for (genvar c = 0; c < LANES; c++) begin : g_lane
    hgov_lane u_lane (
      .clk_i     (clk_i),
      .en_i      (state_q == ST_LANE),
      .online_i  (core_online_q[c]),
      .freq_en_i (c != 0),
      .load_i    (load_q[c]),
      .prio_i    (cfg.core_priorities[c*PRIO_W +: PRIO_W]),
      .freq_i    (freq_q[c]),
      .lane_o    (lane_q[c])
    );
  end

  hgov_merge #(
    .LANES (LANES)
  ) u_merge (
    .clk_i   (clk_i),
    .en_i    (state_q == ST_MERGE),
    .lane_i  (lane_q),
    .merge_o (merge_q)
  );

  // --------------------------------------------------------------------------
  // Decision
  // --------------------------------------------------------------------------
  assign prod3 = PROD_W'(merge_q.sum) * PROD_W'(DIV3_MUL);

  always_comb begin
    case (merge_q.count)
      3'd1:    avg_full = merge_q.sum;
      3'd2:    avg_full = merge_q.sum >> 1;
      3'd3:    avg_full = SUM_W'(prod3 >> DIV3_SHIFT);
      3'd4:    avg_full = merge_q.sum >> 2;
      default: avg_full = '0;
    endcase
  end

  always_comb begin
    logic [CNT_W-1:0]  cnt;
    logic [HOLD_W-1:0] up_n;
    logic [HOLD_W-1:0] down_n;

    online_d  = core_online_q;
    up_d      = up_q;
    down_d    = down_q;
    paused_d  = paused_q;
    action_d  = ACT_NONE;
    changed_d = '0;
    avg_d     = '0;
    cnt       = merge_q.count;
    up_n      = (up_q < cfg.up_hold_ticks) ? up_q + HOLD_W'(1) : up_q;
    down_n    = (down_q < cfg.down_hold_ticks) ? down_q + HOLD_W'(1) : down_q;

    case (cmd_e'(cmd_q))
      CMD_TICK: begin
        if (!paused_q) begin
          avg_d  = avg_full[LOAD_W-1:0];
          up_d   = up_n;
          down_d = down_n;
          if (avg_full >= SUM_W'(cfg.load_threshold) && up_n >= cfg.up_hold_ticks) begin
            if (cnt < cfg.max_cores && merge_q.first_off_ok) begin
              online_d[merge_q.first_off] = 1'b1;
              action_d  = ACT_UP;
              changed_d = merge_q.first_off;
            end
            up_d   = '0;
            down_d = '0;
          end else if (down_n >= cfg.down_hold_ticks) begin
            if (cnt != cfg.min_cores && merge_q.victim_ok) begin
              online_d[merge_q.victim] = 1'b0;
              action_d  = ACT_DOWN;
              changed_d = merge_q.victim;
            end
            up_d   = '0;
            down_d = '0;
          end
        end
      end
      CMD_SCREEN_OFF: begin
        for (int c = 1; c < LANES; c++) begin
          if (cnt > cfg.screen_off_cores) begin
            if (online_d[c]) begin
              cnt = cnt - CNT_W'(1);
            end
            online_d[c] = 1'b0;
          end
        end
        paused_d = 1'b1;
        action_d = ACT_SCREEN;
      end
      CMD_SCREEN_ON: begin
        for (int c = 0; c < LANES; c++) begin
          if (!online_d[c] && cnt < cfg.max_cores) begin
            online_d[c] = 1'b1;
            cnt = cnt + CNT_W'(1);
          end
        end
        down_d   = '0;
        paused_d = 1'b0;
        action_d = ACT_SCREEN;
      end
      default: ;
    endcase
  end

  // --------------------------------------------------------------------------
  // Sequencer and state
  // --------------------------------------------------------------------------
  assign commit = (state_q == ST_DECIDE) && (!out_valid_q || out_o.ready);

  always_comb begin
    case (state_q)
      ST_IDLE:   state_d = in_accept ? ST_LANE : ST_IDLE;
      ST_LANE:   state_d = ST_MERGE;
      ST_MERGE:  state_d = ST_DECIDE;
      ST_DECIDE: state_d = commit ? ST_IDLE : ST_DECIDE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      core_online_q <= LANE_MASK;
      up_q          <= '0;
      down_q        <= '0;
      paused_q      <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if (commit) begin
        core_online_q <= online_d;
        up_q          <= up_d;
        down_q        <= down_d;
        paused_q      <= paused_d;
        out_valid_q   <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit) begin
      out_mask_q   <= online_d;
      out_action_q <= action_d;
      out_core_q   <= changed_d;
      out_avg_q    <= avg_d;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.online_mask  = out_mask_q;
  assign out_o.action       = out_action_q;
  assign out_o.changed_core = out_core_q;
  assign out_o.average_load = out_avg_q;

endmodule

@@ tb/hgov_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hgov_checker
// Watches the item, result and configuration ports of the hotplug governor,
// predicts every decision from its own copy of the governor state and
// compares each result transfer field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module hgov_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  hgov_in_if                           in_ch,
  hgov_out_if                          out_ch,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic                         pready,
  input  logic [hgov_pkg::PADDR_W-1:0] paddr,
  input  logic [hgov_pkg::PDATA_W-1:0] pwdata,
  output int unsigned                  owed_o,
  output int unsigned                  mismatches_o
);
  import hgov_pkg::*;

  typedef struct packed {
    logic [CMD_W-1:0]                 cmd;
    logic [MAX_LANES-1:0][LOAD_W-1:0] load;
    logic [MAX_LANES-1:0][FREQ_W-1:0] freq;
  } gov_item_t;

  typedef struct packed {
    logic [MAX_LANES-1:0]  online_mask;
    logic [ACTION_W-1:0]   action;
    logic [LANE_IDX_W-1:0] changed_core;
    logic [LOAD_W-1:0]     average_load;
  } gov_result_t;

  cfg_t                 cfg;
  logic [MAX_LANES-1:0] online;
  logic [HOLD_W-1:0]    up_cnt;
  logic [HOLD_W-1:0]    dn_cnt;
  logic                 paused;
  gov_result_t          decision_q[$];
  int unsigned          mismatch_cnt;
  gov_item_t            seen_item;
  gov_result_t          seen_result;
  gov_result_t          want;

  task automatic compare_field(input string field, input logic [31:0] exp_val,
                               input logic [31:0] act_val);
    if (act_val !== exp_val) begin
      mismatch_cnt++;
      $display("%0t: %s expected %0d, got %0d", $time, field, exp_val, act_val);
    end
  endtask

  task automatic apply_reg_write(input logic [PADDR_W-1:0] addr,
                                 input logic [PDATA_W-1:0] data);
    case (addr[PADDR_W-1:2])
      REG_LOAD_THRESHOLD:   cfg.load_threshold   = data[LOAD_W-1:0];
      REG_MIN_CORES:        cfg.min_cores        = data[CNT_W-1:0];
      REG_MAX_CORES:        cfg.max_cores        = data[CNT_W-1:0];
      REG_UP_HOLD_TICKS:    cfg.up_hold_ticks    = data[HOLD_W-1:0];
      REG_DOWN_HOLD_TICKS:  cfg.down_hold_ticks  = data[HOLD_W-1:0];
      REG_SCREEN_OFF_CORES: cfg.screen_off_cores = data[CNT_W-1:0];
      REG_CORE_PRIORITIES:  cfg.core_priorities  = data[PRIOS_W-1:0];
      default: ;
    endcase
  endtask

  // Advances the governor state by one item and returns the result it causes.
  task automatic forecast_decision(input gov_item_t it, output gov_result_t r);
    int unsigned      sum;
    int unsigned      n;
    int unsigned      avg;
    int unsigned      prio;
    int unsigned      best_prio;
    int unsigned      best_core;
    int unsigned      slow_core;
    int unsigned      victim;
    logic [FREQ_W:0]  slow_freq;
    logic             shared;
    logic             have_slow;
    logic             placed;
    r = '0;
    n = $countones(online);
    case (it.cmd)
      CMD_TICK: begin
        if (!paused) begin
          if (dn_cnt < cfg.down_hold_ticks) dn_cnt++;
          if (up_cnt < cfg.up_hold_ticks) up_cnt++;
          sum = 0;
          for (int c = 0; c < MAX_LANES; c++) begin
            if (online[c]) sum += 32'(it.load[c]);
          end
          avg = (n != 0) ? sum / n : 0;
          r.average_load = LOAD_W'(avg);
          if (avg >= cfg.load_threshold && up_cnt >= cfg.up_hold_ticks) begin
            if (n < cfg.max_cores) begin
              placed = 1'b0;
              for (int c = 0; c < MAX_LANES; c++) begin
                if (!placed && !online[c]) begin
                  online[c] = 1'b1;
                  r.action = ACT_UP;
                  r.changed_core = LANE_IDX_W'(c);
                  placed = 1'b1;
                end
              end
            end
            up_cnt = '0;
            dn_cnt = '0;
          end else if (dn_cnt >= cfg.down_hold_ticks) begin
            if (n != cfg.min_cores) begin
              best_prio = 0;
              best_core = 0;
              shared = 1'b0;
              slow_freq = '1;
              slow_core = 0;
              have_slow = 1'b0;
              // A tie at the highest threshold (core 0 always counts as one)
              // hands the choice to the slowest core.
              for (int c = 0; c < MAX_LANES; c++) begin
                if (online[c]) begin
                  prio = 32'(cfg.core_priorities[PRIO_W*c +: PRIO_W]);
                  if (c == 0 || prio == best_prio) begin
                    best_prio = prio;
                    best_core = c;
                    shared = 1'b1;
                  end else if (prio > best_prio) begin
                    best_prio = prio;
                    best_core = c;
                    shared = 1'b0;
                  end
                  if (c != 0 && slow_freq > it.freq[c]) begin
                    slow_freq = (FREQ_W+1)'(it.freq[c]);
                    slow_core = c;
                    have_slow = 1'b1;
                  end
                end
              end
              victim = shared ? (have_slow ? slow_core : 0) : best_core;
              if (victim != 0) begin
                online[victim] = 1'b0;
                r.action = ACT_DOWN;
                r.changed_core = LANE_IDX_W'(victim);
              end
            end
            up_cnt = '0;
            dn_cnt = '0;
          end
        end
      end
      CMD_SCREEN_OFF: begin
        for (int c = 1; c < MAX_LANES; c++) begin
          if ($countones(online) > cfg.screen_off_cores) online[c] = 1'b0;
        end
        paused = 1'b1;
        r.action = ACT_SCREEN;
      end
      CMD_SCREEN_ON: begin
        for (int c = 0; c < MAX_LANES; c++) begin
          if (!online[c] && $countones(online) < cfg.max_cores) online[c] = 1'b1;
        end
        dn_cnt = '0;
        paused = 1'b0;
        r.action = ACT_SCREEN;
      end
      default: ;
    endcase
    r.online_mask = online;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg = CFG_RESET;
      online = '1;
      up_cnt = '0;
      dn_cnt = '0;
      paused = 1'b0;
      decision_q.delete();
      mismatch_cnt = 0;
      owed_o <= 0;
      mismatches_o <= 0;
    end else begin
      // A result can never belong to an item accepted at the same edge.
      if (out_ch.valid && out_ch.ready) begin
        seen_result.online_mask  = out_ch.online_mask;
        seen_result.action       = out_ch.action;
        seen_result.changed_core = out_ch.changed_core;
        seen_result.average_load = out_ch.average_load;
        if (decision_q.size() == 0) begin
          mismatch_cnt++;
          $display("%0t: result transfer with nothing outstanding: mask %h action %0d",
                   $time, seen_result.online_mask, seen_result.action);
        end else begin
          want = decision_q.pop_front();
          compare_field("online_mask", 32'(want.online_mask),
                        32'(seen_result.online_mask));
          compare_field("action", 32'(want.action), 32'(seen_result.action));
          compare_field("changed_core", 32'(want.changed_core),
                        32'(seen_result.changed_core));
          compare_field("average_load", 32'(want.average_load),
                        32'(seen_result.average_load));
        end
      end
      if (psel && penable && pwrite && pready) apply_reg_write(paddr, pwdata);
      if (in_ch.valid && in_ch.ready) begin
        seen_item.cmd     = in_ch.cmd;
        seen_item.load[0] = in_ch.load_core0;
        seen_item.load[1] = in_ch.load_core1;
        seen_item.load[2] = in_ch.load_core2;
        seen_item.load[3] = in_ch.load_core3;
        seen_item.freq[0] = '0;
        seen_item.freq[1] = in_ch.freq_core1;
        seen_item.freq[2] = in_ch.freq_core2;
        seen_item.freq[3] = in_ch.freq_core3;
        forecast_decision(seen_item, want);
        decision_q.push_back(want);
      end
      owed_o <= decision_q.size();
      mismatches_o <= mismatch_cnt;
    end
  end

endmodule

@@ tb/tb_core_hotplug_governor_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_core_hotplug_governor_unit
// Drives the hotplug governor with a directed sequence and then with random
// phases of ticks and screen events under changing configurations and idling
// patterns; a checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_core_hotplug_governor_unit;
  import hgov_pkg::*;

  localparam int unsigned       CYCLE_LIMIT  = 400000;
  localparam int unsigned       DRAIN_CYCLES = 20;
  localparam int unsigned       PHASES       = 6;
  localparam int unsigned       PHASE_ITEMS  = 125;
  localparam int unsigned       LONG_HOLD    = 300;
  localparam int unsigned       MAX_GAP      = 20;
  localparam logic [CMD_W-1:0]  CMD_UNUSED   = 2'd3;
  localparam logic [2:0]        REG_UNMAPPED = 3'd7;
  localparam logic [FREQ_W-1:0] FREQ_MAX     = '1;

  logic               clk_i;
  logic               rst_ni;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  int unsigned tx_idle_pct;
  int unsigned rx_idle_pct;
  int unsigned hold_req;
  int unsigned decisions_owed;
  int unsigned mismatch_count;
  int unsigned cycle_cnt;
  cfg_t        cfg_now;
  bit          hot_load;
  bit          screen_off;

  hgov_in_if  in_ch ();
  hgov_out_if out_ch ();

  core_hotplug_governor_unit dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_ch),
    .out_o   (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  hgov_checker gov_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_ch        (in_ch),
    .out_ch       (out_ch),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .pready       (pready),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .owed_o       (decisions_owed),
    .mismatches_o (mismatch_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Result side: random stalls, plus one long hold-off on request.
  initial begin
    int unsigned hold_left;
    int unsigned holds_served;
    hold_left = 0;
    holds_served = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (holds_served != hold_req) begin
        holds_served = hold_req;
        hold_left = LONG_HOLD;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("Some tests failed");
    $finish;
  end

  function automatic logic [PRIOS_W-1:0] pack_prios(input logic [PRIO_W-1:0] p0,
      input logic [PRIO_W-1:0] p1, input logic [PRIO_W-1:0] p2,
      input logic [PRIO_W-1:0] p3);
    return {p3, p2, p1, p0};
  endfunction

  // Upper data bits carry noise; the register keeps only its own width.
  task automatic write_reg(input logic [2:0] idx, input logic [PDATA_W-1:0] value,
                           input int unsigned width);
    logic [PDATA_W-1:0] mask;
    mask = (PDATA_W'(1) << width) - 1;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= ($urandom() & ~mask) | (value & mask);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
  endtask

  task automatic set_config(input cfg_t c);
    write_reg(REG_LOAD_THRESHOLD, PDATA_W'(c.load_threshold), LOAD_W);
    write_reg(REG_MIN_CORES, PDATA_W'(c.min_cores), CNT_W);
    write_reg(REG_MAX_CORES, PDATA_W'(c.max_cores), CNT_W);
    write_reg(REG_UP_HOLD_TICKS, PDATA_W'(c.up_hold_ticks), HOLD_W);
    write_reg(REG_DOWN_HOLD_TICKS, PDATA_W'(c.down_hold_ticks), HOLD_W);
    write_reg(REG_SCREEN_OFF_CORES, PDATA_W'(c.screen_off_cores), CNT_W);
    write_reg(REG_CORE_PRIORITIES, PDATA_W'(c.core_priorities), PRIOS_W);
    write_reg(REG_UNMAPPED, $urandom(), PDATA_W);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    cfg_now = c;
  endtask

  task automatic wait_drained();
    if (in_ch.valid) in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (decisions_owed != 0) @(posedge clk_i);
  endtask

  // Valid stays high after a transfer unless the next item starts with a gap.
  task automatic offer(input logic [CMD_W-1:0] cmd,
      input logic [LOAD_W-1:0] l0, input logic [LOAD_W-1:0] l1,
      input logic [LOAD_W-1:0] l2, input logic [LOAD_W-1:0] l3,
      input logic [FREQ_W-1:0] f1, input logic [FREQ_W-1:0] f2,
      input logic [FREQ_W-1:0] f3);
    int unsigned gap;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(99) < tx_idle_pct) gap++;
    if (gap != 0) begin
      if (in_ch.valid) in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid      <= 1'b1;
    in_ch.cmd        <= cmd;
    in_ch.load_core0 <= l0;
    in_ch.load_core1 <= l1;
    in_ch.load_core2 <= l2;
    in_ch.load_core3 <= l3;
    in_ch.freq_core1 <= f1;
    in_ch.freq_core2 <= f2;
    in_ch.freq_core3 <= f3;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
  endtask

  // Mostly ticks in runs of high or low load, so that the hold counters fill
  // up and cores come and go; screen-off is usually followed by screen-on.
  task automatic offer_random();
    logic [CMD_W-1:0]  cmd;
    logic [LOAD_W-1:0] ld[MAX_LANES];
    logic [FREQ_W-1:0] fq[MAX_LANES];
    int unsigned       roll;
    int unsigned       thr;
    roll = $urandom_range(99);
    if (screen_off) begin
      cmd = (roll < 45) ? CMD_SCREEN_ON : (roll < 90) ? CMD_TICK :
            (roll < 97) ? CMD_SCREEN_OFF : CMD_UNUSED;
    end else begin
      cmd = (roll < 86) ? CMD_TICK : (roll < 92) ? CMD_SCREEN_OFF :
            (roll < 98) ? CMD_SCREEN_ON : CMD_UNUSED;
    end
    if (cmd == CMD_SCREEN_OFF) screen_off = 1'b1;
    else if (cmd == CMD_SCREEN_ON) screen_off = 1'b0;
    if ($urandom_range(99) < 10) hot_load = !hot_load;
    thr = 32'(cfg_now.load_threshold);
    for (int c = 0; c < MAX_LANES; c++) begin
      roll = $urandom_range(99);
      if (roll < 15) ld[c] = LOAD_W'($urandom_range(127, 0));
      else if (hot_load) ld[c] = LOAD_W'($urandom_range(127, thr));
      else ld[c] = (thr == 0) ? '0 : LOAD_W'($urandom_range(thr - 1, 0));
    end
    fq[0] = '0;
    roll = $urandom_range(99);
    for (int c = 1; c < MAX_LANES; c++) begin
      if (roll < 30) fq[c] = FREQ_W'($urandom_range(3, 0));
      else if (roll < 38) fq[c] = FREQ_MAX;
      else fq[c] = FREQ_W'($urandom());
    end
    offer(cmd, ld[0], ld[1], ld[2], ld[3], fq[1], fq[2], fq[3]);
  endtask

  function automatic logic [PRIO_W-1:0] random_prio();
    return PRIO_W'($urandom_range(100, 0));
  endfunction

  function automatic logic [PRIO_W-1:0] coin_prio();
    return ($urandom_range(1) != 0) ? PRIO_W'(30) : PRIO_W'(60);
  endfunction

  function automatic cfg_t phase_config(input int unsigned phase);
    cfg_t        c;
    logic [PRIO_W-1:0] p[MAX_LANES];
    for (int i = 0; i < MAX_LANES; i++) begin
      p[i] = random_prio();
      // Frequent ties between neighbouring thresholds exercise the frequency pick.
      if (i != 0 && $urandom_range(3) == 0) p[i] = p[i-1];
    end
    c.core_priorities = pack_prios(p[0], p[1], p[2], p[3]);
    case (phase)
      0: begin
        c.load_threshold   = LOAD_W'($urandom_range(90, 40));
        c.min_cores        = CNT_W'($urandom_range(2, 1));
        c.max_cores        = CNT_W'($urandom_range(4, 3));
        c.up_hold_ticks    = HOLD_W'($urandom_range(4, 1));
        c.down_hold_ticks  = HOLD_W'($urandom_range(6, 1));
        c.screen_off_cores = CNT_W'($urandom_range(3, 1));
      end
      1: begin
        c.load_threshold   = 7'd1;
        c.min_cores        = 3'd1;
        c.max_cores        = 3'd1;
        c.up_hold_ticks    = 6'd1;
        c.down_hold_ticks  = 6'd1;
        c.screen_off_cores = 3'd1;
      end
      2: begin
        c.load_threshold   = 7'd100;
        c.min_cores        = 3'd4;
        c.max_cores        = 3'd4;
        c.up_hold_ticks    = 6'd50;
        c.down_hold_ticks  = 6'd50;
        c.screen_off_cores = 3'd4;
        c.core_priorities  = pack_prios(7'd100, 7'd100, 7'd100, 7'd100);
      end
      3: begin
        c.load_threshold   = LOAD_W'($urandom_range(100, 1));
        c.min_cores        = 3'd2;
        c.max_cores        = 3'd3;
        c.up_hold_ticks    = 6'd2;
        c.down_hold_ticks  = 6'd3;
        c.screen_off_cores = 3'd2;
        c.core_priorities  = pack_prios(coin_prio(), coin_prio(), coin_prio(),
                                        coin_prio());
      end
      4: begin
        // Values beyond the documented ranges.
        c.load_threshold   = 7'd127;
        c.min_cores        = 3'd0;
        c.max_cores        = 3'd7;
        c.up_hold_ticks    = 6'd0;
        c.down_hold_ticks  = 6'd0;
        c.screen_off_cores = 3'd0;
        c.core_priorities  = pack_prios(7'd127, random_prio(), 7'd127, random_prio());
      end
      default: begin
        c.load_threshold   = LOAD_W'($urandom());
        c.min_cores        = CNT_W'($urandom());
        c.max_cores        = CNT_W'($urandom());
        c.up_hold_ticks    = HOLD_W'($urandom_range(8, 0));
        c.down_hold_ticks  = HOLD_W'($urandom_range(8, 0));
        c.screen_off_cores = CNT_W'($urandom());
        c.core_priorities  = PRIOS_W'($urandom());
      end
    endcase
    return c;
  endfunction

  initial begin
    rst_ni           <= 1'b0;
    psel             <= 1'b0;
    penable          <= 1'b0;
    pwrite           <= 1'b0;
    paddr            <= '0;
    pwdata           <= '0;
    in_ch.valid      <= 1'b0;
    in_ch.cmd        <= CMD_TICK;
    in_ch.load_core0 <= '0;
    in_ch.load_core1 <= '0;
    in_ch.load_core2 <= '0;
    in_ch.load_core3 <= '0;
    in_ch.freq_core1 <= '0;
    in_ch.freq_core2 <= '0;
    in_ch.freq_core3 <= '0;
    tx_idle_pct = 30;
    rx_idle_pct = 62;
    hold_req = 0;
    hot_load = 1'b0;
    screen_off = 1'b0;
    cfg_now = CFG_RESET;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset configuration: the up counter is not yet full.
    offer(CMD_TICK, 100, 100, 100, 100, 1, 2, 3);
    offer(CMD_TICK, 0, 0, 0, 0, FREQ_MAX, 0, FREQ_MAX);

    // Equal thresholds everywhere, so every down step picks the slowest core.
    wait_drained();
    set_config('{load_threshold: 7'd50, min_cores: 3'd1, max_cores: 3'd4,
                 up_hold_ticks: 6'd1, down_hold_ticks: 6'd1, screen_off_cores: 3'd1,
                 core_priorities: pack_prios(7'd70, 7'd70, 7'd70, 7'd70)});
    offer(CMD_TICK, 100, 100, 100, 100, 0, 0, 0);
    offer(CMD_TICK, 0, 0, 0, 0, 5, 5, 9);
    offer(CMD_TICK, 0, 0, 0, 0, FREQ_MAX, FREQ_MAX, 0);
    offer(CMD_TICK, 0, 0, 0, 0, FREQ_MAX, FREQ_MAX, FREQ_MAX);
    offer(CMD_TICK, 0, 0, 0, 0, 0, 0, 0);
    offer(CMD_TICK, 127, 0, 0, 0, 0, 0, 0);
    offer(CMD_TICK, 100, 100, 100, 100, 0, 0, 0);
    offer(CMD_TICK, 100, 100, 100, 100, 0, 0, 0);
    offer(CMD_SCREEN_OFF, 0, 0, 0, 0, 0, 0, 0);
    offer(CMD_TICK, 100, 100, 100, 100, 0, 0, 0);
    offer(CMD_UNUSED, 127, 127, 127, 127, FREQ_MAX, FREQ_MAX, FREQ_MAX);
    offer(CMD_SCREEN_ON, 0, 0, 0, 0, 0, 0, 0);

    // Online count above the cap, a tie at the highest threshold, and a floor of zero
    // where only core 0 would be left to take down.
    wait_drained();
    set_config('{load_threshold: 7'd100, min_cores: 3'd0, max_cores: 3'd2,
                 up_hold_ticks: 6'd1, down_hold_ticks: 6'd1, screen_off_cores: 3'd4,
                 core_priorities: pack_prios(7'd10, 7'd90, 7'd90, 7'd50)});
    offer(CMD_TICK, 100, 100, 100, 100, 0, 0, 0);
    offer(CMD_TICK, 0, 0, 0, 0, 7, 3, 1);
    offer(CMD_TICK, 0, 0, 0, 0, 8, 8, 8);
    offer(CMD_TICK, 0, 0, 0, 0, 8, 8, 8);
    offer(CMD_TICK, 0, 0, 0, 0, 8, 8, 8);
    offer(CMD_SCREEN_ON, 0, 0, 0, 0, 0, 0, 0);
    offer(CMD_SCREEN_OFF, 0, 0, 0, 0, 0, 0, 0);
    offer(CMD_TICK, 0, 0, 0, 0, 0, 0, 0);
    offer(CMD_SCREEN_ON, 0, 0, 0, 0, 0, 0, 0);

    for (int unsigned ph = 0; ph < PHASES; ph++) begin
      tx_idle_pct = (ph < 2) ? 30 : (ph < 4) ? 62 : 0;
      rx_idle_pct = (ph < 2) ? 62 : (ph < 4) ? 30 : 0;
      wait_drained();
      set_config(phase_config(ph));
      for (int unsigned n = 0; n < PHASE_ITEMS; n++) begin
        if (ph == 0 && n == 40) hold_req++;
        if (ph == 2 && n == 60) wait_drained();
        offer_random();
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
